[rtl/sit_pkg.sv]
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types, widths and helper functions of the segment intersection test.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int NUM_COORDS  = 8;
    localparam int NUM_ORIENT  = 4;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int TOL_W       = 16;
    localparam int IN_TDATA_W  = ((NUM_COORDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [CROSS_W-1:0]     cross_t;
    typedef logic [TOL_W-1:0]              tol_t;

    typedef enum logic [1:0] {
        ORIENT_COL,
        ORIENT_CW,
        ORIENT_CCW
    } orient_t;

    typedef struct packed {
        diff_t pq_x;
        diff_t pq_y;
        diff_t qr_x;
        diff_t qr_y;
    } orient_diff_t;

    typedef struct packed {
        prod_t a;
        prod_t b;
    } orient_prod_t;

    function automatic diff_t coord_sub(coord_t a, coord_t b);
        diff_t r;
        r = diff_t'(a) - diff_t'(b);
        return r;
    endfunction

    function automatic logic in_range(coord_t q, coord_t p, coord_t r);
        logic hit;
        hit = (q >= p && q <= r) || (q >= r && q <= p);
        return hit;
    endfunction

    function automatic orient_t classify(cross_t v, tol_t tol);
        cross_t  t;
        orient_t o;
        t = cross_t'(tol);
        if (v <= t && v >= -t)
            o = ORIENT_COL;
        else if (!v[CROSS_W-1])
            o = ORIENT_CW;
        else
            o = ORIENT_CCW;
        return o;
    endfunction

endpackage

[rtl/segment_intersection_test_unit.sv]
// ----------------------------------------------------------------------------
// segment_intersection_test_unit
// Throughput: one segment pair per cycle unless output stalls; each stage has
// its own hold logic, so empty stages fill while the output register waits.
// Reset: asynchronous, active low; clears valid bits and the tolerance to 0.
// Stages: differences and box tests, products, cross sums, classify and hit.
// ----------------------------------------------------------------------------
module segment_intersection_test_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sit_pkg::TOL_W-1:0]        cfg_data,      // collinear_tolerance
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
    // seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y
    input  logic [sit_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sit_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // intersects
);

    sit_pkg::tol_t         tol_reg;

    sit_pkg::coord_t       c [sit_pkg::NUM_COORDS];
    sit_pkg::orient_diff_t d1_next [sit_pkg::NUM_ORIENT];
    logic [sit_pkg::NUM_ORIENT-1:0] box1_next;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic                  ready1, ready2, ready3, ready4;

    sit_pkg::orient_diff_t d1_reg [sit_pkg::NUM_ORIENT];
    logic [sit_pkg::NUM_ORIENT-1:0] box1_reg;
    sit_pkg::orient_prod_t p2_reg [sit_pkg::NUM_ORIENT];
    logic [sit_pkg::NUM_ORIENT-1:0] box2_reg;
    sit_pkg::cross_t       x3_reg [sit_pkg::NUM_ORIENT];
    logic [sit_pkg::NUM_ORIENT-1:0] box3_reg;
    sit_pkg::orient_t      o [sit_pkg::NUM_ORIENT];
    logic                  hit_next;
    logic                  hit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg_valid)
            tol_reg <= cfg_data;
    end

    assign ready4        = !v4_reg || m_axis_tready;
    assign ready3        = !v3_reg || ready4;
    assign ready2        = !v2_reg || ready3;
    assign ready1        = !v1_reg || ready2;
    assign s_axis_tready = ready1;

    always_comb
    begin
        for (int i = 0; i < sit_pkg::NUM_COORDS; i++)
            c[i] = s_axis_tdata[i*sit_pkg::COORD_WIDTH +: sit_pkg::COORD_WIDTH];
    end

    // c[0..1] = P1, c[2..3] = Q1, c[4..5] = P2, c[6..7] = Q2
    always_comb
    begin
        d1_next[0].pq_x = sit_pkg::coord_sub(c[2], c[0]);
        d1_next[0].pq_y = sit_pkg::coord_sub(c[3], c[1]);
        d1_next[0].qr_x = sit_pkg::coord_sub(c[4], c[2]);
        d1_next[0].qr_y = sit_pkg::coord_sub(c[5], c[3]);
        d1_next[1].pq_x = sit_pkg::coord_sub(c[2], c[0]);
        d1_next[1].pq_y = sit_pkg::coord_sub(c[3], c[1]);
        d1_next[1].qr_x = sit_pkg::coord_sub(c[6], c[2]);
        d1_next[1].qr_y = sit_pkg::coord_sub(c[7], c[3]);
        d1_next[2].pq_x = sit_pkg::coord_sub(c[6], c[4]);
        d1_next[2].pq_y = sit_pkg::coord_sub(c[7], c[5]);
        d1_next[2].qr_x = sit_pkg::coord_sub(c[0], c[6]);
        d1_next[2].qr_y = sit_pkg::coord_sub(c[1], c[7]);
        d1_next[3].pq_x = sit_pkg::coord_sub(c[6], c[4]);
        d1_next[3].pq_y = sit_pkg::coord_sub(c[7], c[5]);
        d1_next[3].qr_x = sit_pkg::coord_sub(c[2], c[6]);
        d1_next[3].qr_y = sit_pkg::coord_sub(c[3], c[7]);

        box1_next[0] = sit_pkg::in_range(c[4], c[0], c[2])
                    && sit_pkg::in_range(c[5], c[1], c[3]);
        box1_next[1] = sit_pkg::in_range(c[6], c[0], c[2])
                    && sit_pkg::in_range(c[7], c[1], c[3]);
        box1_next[2] = sit_pkg::in_range(c[0], c[4], c[6])
                    && sit_pkg::in_range(c[1], c[5], c[7]);
        box1_next[3] = sit_pkg::in_range(c[2], c[4], c[6])
                    && sit_pkg::in_range(c[3], c[5], c[7]);
    end

    always_comb
    begin
        for (int i = 0; i < sit_pkg::NUM_ORIENT; i++)
            o[i] = sit_pkg::classify(x3_reg[i], tol_reg);
        hit_next = ((o[0] != o[1]) && (o[2] != o[3]))
                || ((o[0] == sit_pkg::ORIENT_COL) && box3_reg[0])
                || ((o[1] == sit_pkg::ORIENT_COL) && box3_reg[1])
                || ((o[2] == sit_pkg::ORIENT_COL) && box3_reg[2])
                || ((o[3] == sit_pkg::ORIENT_COL) && box3_reg[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= s_axis_tvalid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
            if (ready4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            d1_reg   <= d1_next;
            box1_reg <= box1_next;
        end
        if (ready2)
        begin
            for (int i = 0; i < sit_pkg::NUM_ORIENT; i++)
            begin
                p2_reg[i].a <= sit_pkg::prod_t'(d1_reg[i].pq_y)
                             * sit_pkg::prod_t'(d1_reg[i].qr_x);
                p2_reg[i].b <= sit_pkg::prod_t'(d1_reg[i].pq_x)
                             * sit_pkg::prod_t'(d1_reg[i].qr_y);
            end
            box2_reg <= box1_reg;
        end
        if (ready3)
        begin
            for (int i = 0; i < sit_pkg::NUM_ORIENT; i++)
                x3_reg[i] <= sit_pkg::cross_t'(p2_reg[i].a)
                           - sit_pkg::cross_t'(p2_reg[i].b);
            box3_reg <= box2_reg;
        end
        if (ready4)
            hit_reg <= hit_next;
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {{(sit_pkg::OUT_TDATA_W-1){1'b0}}, hit_reg};

`ifndef SYNTH
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    a_accept_enters_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v1_reg)
        else $error("accepted transfer lost at first stage");

    a_full_pipe_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && m_axis_tvalid && !m_axis_tready)
        |-> !s_axis_tready)
        else $error("input taken while every stage is full and stalled");

    a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !ready4) |=> (v3_reg && $stable(box3_reg)))
        else $error("stalled stage three item dropped or changed");
`endif

endmodule
